[rtl/core/dwq_pkg.sv]
// Shared constants and codes for the dedup work queue.
package dwq_pkg;

  localparam int QueueDepth = 16;
  localparam int IdW        = 6;
  localparam int NumWorkIds = 1 << IdW;
  localparam int OpW        = 3;
  localparam int SeqW       = 32;
  localparam int QIdxW      = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);

  typedef enum logic [OpW-1:0] {
    OP_QUEUE       = 3'd0,
    OP_CANCEL      = 3'd1,
    OP_CANCEL_SYNC = 3'd2,
    OP_FLUSH       = 3'd3,
    OP_CLEAR       = 3'd4
  } op_e;

endpackage

[rtl/core/dwq_if.sv]
// Request and result channel interfaces of the dedup work queue.
interface dwq_req_if;
  logic                     valid;
  logic                     ready;
  logic [dwq_pkg::OpW-1:0]  operation;
  logic [dwq_pkg::IdW-1:0]  work_id;

  modport source (output valid, operation, work_id, input ready);
  modport sink   (input valid, operation, work_id, output ready);
endinterface

interface dwq_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic                      dispatched;
  logic [dwq_pkg::IdW-1:0]   dispatched_id;
  logic [dwq_pkg::SeqW-1:0]  run_stamp;
  logic [dwq_pkg::SeqW-1:0]  run_count;
  logic [dwq_pkg::CntW-1:0]  pending_count;
  logic                      last;

  modport source (output valid, accepted, dispatched, dispatched_id, run_stamp, run_count,
                  pending_count, last, input ready);
  modport sink   (input valid, accepted, dispatched, dispatched_id, run_stamp, run_count,
                  pending_count, last, output ready);
endinterface

[rtl/core/dwq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dwq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/dedup_work_queue_with_cancel_unit.sv]
// Queue, clear, non-pending cancel, empty flush: counter read, then result registered.
// Cancel of a pending id: read and check of each ring entry (up to ring depth), then result path.
// Flush: per dispatched entry a ring read, counter read and counter write-back with its result.
// One item in flight; the next is accepted once the last result is in the output register.
// Reset clears ring pointers, pending bits, counter-entry valid bits and the run sequence;
// counter entries read as zero until written, so no clearing pass; ring memory is not cleared.
module dedup_work_queue_with_cancel_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  dwq_req_if.sink    req_i,
  dwq_rsp_if.source  rsp_o
);

  localparam int CntMemW = 2 * dwq_pkg::SeqW;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_RES_RD   = 8'b0000_0010,
    S_RES_OUT  = 8'b0000_0100,
    S_SCAN_RD  = 8'b0000_1000,
    S_SCAN_CHK = 8'b0001_0000,
    S_FL_RD    = 8'b0010_0000,
    S_FL_CNT   = 8'b0100_0000,
    S_FL_UPD   = 8'b1000_0000
  } state_e;

  function automatic logic [dwq_pkg::QIdxW-1:0] wrap_add(
    input logic [dwq_pkg::QIdxW-1:0] a,
    input logic [dwq_pkg::QIdxW-1:0] b
  );
    logic [dwq_pkg::QIdxW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (dwq_pkg::QIdxW + 1)'(dwq_pkg::QueueDepth)) begin
      sum = sum - (dwq_pkg::QIdxW + 1)'(dwq_pkg::QueueDepth);
    end
    return sum[dwq_pkg::QIdxW-1:0];
  endfunction

  function automatic logic [dwq_pkg::QIdxW-1:0] wrap_inc(input logic [dwq_pkg::QIdxW-1:0] a);
    return (a == dwq_pkg::QIdxW'(dwq_pkg::QueueDepth - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [dwq_pkg::QIdxW-1:0] wrap_dec(input logic [dwq_pkg::QIdxW-1:0] a);
    return (a == '0) ? dwq_pkg::QIdxW'(dwq_pkg::QueueDepth - 1) : a - 1'b1;
  endfunction

  state_e                        state_q, state_d;
  logic [dwq_pkg::IdW-1:0]       id_q, id_d;
  logic                          acc_q, acc_d;
  logic [dwq_pkg::CntW-1:0]      k_q, k_d;
  logic [dwq_pkg::CntW-1:0]      k_m1;
  logic                          found_q, found_d;
  logic [dwq_pkg::QIdxW-1:0]     head_q, head_d;
  logic [dwq_pkg::QIdxW-1:0]     tail_q, tail_d;
  logic [dwq_pkg::CntW-1:0]      count_q, count_d;
  logic [dwq_pkg::NumWorkIds-1:0] pend_q, pend_d;
  logic [dwq_pkg::NumWorkIds-1:0] cvalid_q, cvalid_d;
  logic [dwq_pkg::SeqW-1:0]      seq_q, seq_d;
  logic [dwq_pkg::SeqW-1:0]      seq_nx, runs_nx;
  logic [dwq_pkg::IdW-1:0]       w_q, w_d;
  logic                          cv_q, cv_d;

  logic                          rsp_vld_q, rsp_vld_d;
  logic                          rsp_acc_q, rsp_acc_d;
  logic                          rsp_disp_q, rsp_disp_d;
  logic [dwq_pkg::IdW-1:0]       rsp_id_q, rsp_id_d;
  logic [dwq_pkg::SeqW-1:0]      rsp_order_q, rsp_order_d;
  logic [dwq_pkg::SeqW-1:0]      rsp_runs_q, rsp_runs_d;
  logic [dwq_pkg::CntW-1:0]      rsp_pend_q, rsp_pend_d;
  logic                          rsp_last_q, rsp_last_d;

  logic                          in_fire, out_free;

  logic                          ring_we, ring_re;
  logic [dwq_pkg::QIdxW-1:0]     ring_waddr, ring_raddr;
  logic [dwq_pkg::IdW-1:0]       ring_wdata, ring_rdata;

  // Counter entry: run order in the upper half, run count in the lower half.
  logic                          cnt_we, cnt_re;
  logic [dwq_pkg::IdW-1:0]       cnt_waddr, cnt_raddr;
  logic [CntMemW-1:0]            cnt_wdata, cnt_rdata;

  dwq_ram #(
    .Width (dwq_pkg::IdW),
    .Depth (dwq_pkg::QueueDepth)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  dwq_ram #(
    .Width (CntMemW),
    .Depth (dwq_pkg::NumWorkIds)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid & req_i.ready;
  assign out_free    = !rsp_vld_q || rsp_o.ready;
  assign k_m1        = k_q - 1'b1;
  assign seq_nx      = seq_q + 1'b1;
  assign runs_nx     = (cv_q ? cnt_rdata[dwq_pkg::SeqW-1:0] : '0) + 1'b1;

  // The canceled mark has no effect on any result, so it is not stored.
  always_comb begin
    state_d     = state_q;
    id_d        = id_q;
    acc_d       = acc_q;
    k_d         = k_q;
    found_d     = found_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    pend_d      = pend_q;
    cvalid_d    = cvalid_q;
    seq_d       = seq_q;
    w_d         = w_q;
    cv_d        = cv_q;
    rsp_vld_d   = rsp_vld_q;
    rsp_acc_d   = rsp_acc_q;
    rsp_disp_d  = rsp_disp_q;
    rsp_id_d    = rsp_id_q;
    rsp_order_d = rsp_order_q;
    rsp_runs_d  = rsp_runs_q;
    rsp_pend_d  = rsp_pend_q;
    rsp_last_d  = rsp_last_q;
    ring_we     = 1'b0;
    ring_waddr  = tail_q;
    ring_wdata  = req_i.work_id;
    ring_re     = 1'b0;
    ring_raddr  = head_q;
    cnt_we      = 1'b0;
    cnt_waddr   = w_q;
    cnt_wdata   = {seq_nx, runs_nx};
    cnt_re      = 1'b0;
    cnt_raddr   = id_q;

    if (rsp_vld_q && rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          id_d    = req_i.work_id;
          acc_d   = 1'b0;
          state_d = S_RES_RD;
          case (req_i.operation)
            dwq_pkg::OP_QUEUE: begin
              if (!pend_q[req_i.work_id] &&
                  count_q < dwq_pkg::CntW'(dwq_pkg::QueueDepth)) begin
                ring_we                = 1'b1;
                tail_d                 = wrap_inc(tail_q);
                count_d                = count_q + 1'b1;
                pend_d[req_i.work_id]  = 1'b1;
                acc_d                  = 1'b1;
              end
            end
            dwq_pkg::OP_CANCEL, dwq_pkg::OP_CANCEL_SYNC: begin
              if (pend_q[req_i.work_id]) begin
                acc_d   = 1'b1;
                k_d     = '0;
                found_d = 1'b0;
                state_d = S_SCAN_RD;
              end
            end
            dwq_pkg::OP_FLUSH: begin
              acc_d = 1'b1;
              if (count_q != '0) begin
                state_d = S_FL_RD;
              end
            end
            dwq_pkg::OP_CLEAR: begin
              acc_d                   = 1'b1;
              cvalid_d[req_i.work_id] = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_RES_RD: begin
        cnt_re    = 1'b1;
        cnt_raddr = id_q;
        cv_d      = cvalid_q[id_q];
        state_d   = S_RES_OUT;
      end
      S_RES_OUT: begin
        if (out_free) begin
          rsp_vld_d   = 1'b1;
          rsp_acc_d   = acc_q;
          rsp_disp_d  = 1'b0;
          rsp_id_d    = id_q;
          rsp_order_d = cv_q ? cnt_rdata[CntMemW-1:dwq_pkg::SeqW] : '0;
          rsp_runs_d  = cv_q ? cnt_rdata[dwq_pkg::SeqW-1:0] : '0;
          rsp_pend_d  = count_q;
          rsp_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        ring_re    = 1'b1;
        ring_raddr = wrap_add(head_q, k_q[dwq_pkg::QIdxW-1:0]);
        state_d    = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        // Past the match, every entry moves one slot toward the head.
        if (found_q) begin
          ring_we    = 1'b1;
          ring_waddr = wrap_add(head_q, k_m1[dwq_pkg::QIdxW-1:0]);
          ring_wdata = ring_rdata;
        end
        found_d = found_q | (ring_rdata == id_q);
        k_d     = k_q + 1'b1;
        if (k_d == count_q) begin
          state_d = S_RES_RD;
          if (found_d) begin
            tail_d       = wrap_dec(tail_q);
            count_d      = count_q - 1'b1;
            pend_d[id_q] = 1'b0;
          end
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_FL_RD: begin
        ring_re    = 1'b1;
        ring_raddr = head_q;
        state_d    = S_FL_CNT;
      end
      S_FL_CNT: begin
        w_d                = ring_rdata;
        cnt_re             = 1'b1;
        cnt_raddr          = ring_rdata;
        cv_d               = cvalid_q[ring_rdata];
        head_d             = wrap_inc(head_q);
        count_d            = count_q - 1'b1;
        pend_d[ring_rdata] = 1'b0;
        state_d            = S_FL_UPD;
      end
      S_FL_UPD: begin
        if (out_free) begin
          cnt_we        = 1'b1;
          cvalid_d[w_q] = 1'b1;
          seq_d         = seq_nx;
          rsp_vld_d     = 1'b1;
          rsp_acc_d     = 1'b1;
          rsp_disp_d    = 1'b1;
          rsp_id_d      = w_q;
          rsp_order_d   = seq_nx;
          rsp_runs_d    = runs_nx;
          rsp_pend_d    = count_q;
          rsp_last_d    = (count_q == '0);
          state_d       = (count_q == '0) ? S_IDLE : S_FL_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      pend_q    <= '0;
      cvalid_q  <= '0;
      seq_q     <= '0;
      rsp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      cvalid_q  <= cvalid_d;
      seq_q     <= seq_d;
      rsp_vld_q <= rsp_vld_d;
      found_q   <= found_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q        <= id_d;
    acc_q       <= acc_d;
    w_q         <= w_d;
    cv_q        <= cv_d;
    rsp_acc_q   <= rsp_acc_d;
    rsp_disp_q  <= rsp_disp_d;
    rsp_id_q    <= rsp_id_d;
    rsp_order_q <= rsp_order_d;
    rsp_runs_q  <= rsp_runs_d;
    rsp_pend_q  <= rsp_pend_d;
    rsp_last_q  <= rsp_last_d;
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.accepted      = rsp_acc_q;
  assign rsp_o.dispatched    = rsp_disp_q;
  assign rsp_o.dispatched_id = rsp_id_q;
  assign rsp_o.run_stamp     = rsp_order_q;
  assign rsp_o.run_count     = rsp_runs_q;
  assign rsp_o.pending_count = rsp_pend_q;
  assign rsp_o.last          = rsp_last_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dwq_pkg::CntW'(dwq_pkg::QueueDepth))
    else $error("ring count exceeds depth");

  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == dwq_pkg::CntW'(dwq_pkg::QueueDepth)) ? (tail_q == head_q)
      : (tail_q == wrap_add(head_q, count_q[dwq_pkg::QIdxW-1:0])))
    else $error("ring tail does not match head plus count");

  a_pending_matches_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pend_q) == int'(count_q))
    else $error("pending bits disagree with ring count");

  a_dispatch_not_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FL_UPD) |-> !pend_q[w_q])
    else $error("dispatched id still marked pending");
`endif

endmodule

[verif/dedup_work_queue_with_cancel_unit_test.sv]
// Self-checking testbench for the dedup work queue: directed table, then random traffic.
module dedup_work_queue_with_cancel_unit_test;

  localparam logic [dwq_pkg::OpW-1:0] OpUnknown = 3'd7;
  localparam int RandItems   = 75;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 60;
  localparam int NumDirRows  = 26;

  typedef struct packed {
    logic                       accepted;
    logic                       dispatched;
    logic [dwq_pkg::IdW-1:0]    dispatched_id;
    logic [dwq_pkg::SeqW-1:0]   run_stamp;
    logic [dwq_pkg::SeqW-1:0]   run_count;
    logic [dwq_pkg::CntW-1:0]   pending_count;
    logic                       last;
  } dwq_result_t;

  typedef struct {
    logic [dwq_pkg::OpW-1:0]  op;
    logic [dwq_pkg::IdW-1:0]  id;
    bit                       typed;
    dwq_result_t              want;
  } stim_row_t;

  localparam dwq_result_t NoWant = '0;

  logic clk_i;
  logic rst_ni;

  dwq_req_if req_bus ();
  dwq_rsp_if rsp_bus ();

  dedup_work_queue_with_cancel_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Queue model: ring kept in order from head, since only that order is visible.
  logic [dwq_pkg::IdW-1:0]   ring_q [$];
  bit                        pend_flag    [dwq_pkg::NumWorkIds];
  bit                        cancel_mark  [dwq_pkg::NumWorkIds];
  logic [dwq_pkg::SeqW-1:0]  last_run_seq [dwq_pkg::NumWorkIds];
  logic [dwq_pkg::SeqW-1:0]  dispatch_tot [dwq_pkg::NumWorkIds];
  logic [dwq_pkg::SeqW-1:0]  run_seq;

  dwq_result_t due_results [$];
  int          mismatches;
  bit          hold_rsp;
  bit          steady;

  // Directed rows: expectations typed only where they follow from reset and the rows before.
  stim_row_t dir_rows [NumDirRows] = '{
    '{dwq_pkg::OP_FLUSH,       6'd63, 1'b1, '{1'b1, 1'b0, 6'd63, 32'd0, 32'd0, 5'd0,  1'b1}},
    '{dwq_pkg::OP_CANCEL,      6'd5,  1'b1, '{1'b0, 1'b0, 6'd5,  32'd0, 32'd0, 5'd0,  1'b1}},
    '{dwq_pkg::OP_CANCEL_SYNC, 6'd9,  1'b1, '{1'b0, 1'b0, 6'd9,  32'd0, 32'd0, 5'd0,  1'b1}},
    '{dwq_pkg::OP_QUEUE,       6'd0,  1'b1, '{1'b1, 1'b0, 6'd0,  32'd0, 32'd0, 5'd1,  1'b1}},
    '{dwq_pkg::OP_QUEUE,       6'd0,  1'b1, '{1'b0, 1'b0, 6'd0,  32'd0, 32'd0, 5'd1,  1'b1}},
    '{dwq_pkg::OP_QUEUE,       6'd63, 1'b1, '{1'b1, 1'b0, 6'd63, 32'd0, 32'd0, 5'd2,  1'b1}},
    '{dwq_pkg::OP_QUEUE,       6'd1,  1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd2,  1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd3,  1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd4,  1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd5,  1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd6,  1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd7,  1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd8,  1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd9,  1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd10, 1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd11, 1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd12, 1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd13, 1'b0, NoWant},
    '{dwq_pkg::OP_QUEUE,       6'd14, 1'b0, NoWant},
    // ring is full here
    '{dwq_pkg::OP_QUEUE,       6'd42, 1'b1, '{1'b0, 1'b0, 6'd42, 32'd0, 32'd0, 5'd16, 1'b1}},
    '{dwq_pkg::OP_CANCEL,      6'd7,  1'b0, NoWant},
    '{dwq_pkg::OP_CANCEL_SYNC, 6'd63, 1'b0, NoWant},
    '{dwq_pkg::OP_FLUSH,       6'd0,  1'b0, NoWant},
    '{dwq_pkg::OP_CLEAR,       6'd0,  1'b1, '{1'b1, 1'b0, 6'd0,  32'd0, 32'd0, 5'd0,  1'b1}},
    '{OpUnknown,               6'd21, 1'b1, '{1'b0, 1'b0, 6'd21, 32'd0, 32'd0, 5'd0,  1'b1}}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advances the queue model by one request and queues the results it should produce (typed rows: the typed one).
  function automatic void work_queue_step(input logic [dwq_pkg::OpW-1:0] op,
                                          input logic [dwq_pkg::IdW-1:0] id,
                                          input bit typed, input dwq_result_t want);
    dwq_result_t             res_q [$];
    logic [dwq_pkg::IdW-1:0] w;
    logic                    acc;
    int                      i;
    acc = 1'b0;
    if (dwq_pkg::op_e'(op) == dwq_pkg::OP_FLUSH && ring_q.size() != 0) begin
      while (ring_q.size() != 0) begin
        w = ring_q.pop_front();
        pend_flag[w] = 1'b0;
        run_seq = run_seq + 1;
        last_run_seq[w] = run_seq;
        dispatch_tot[w] = dispatch_tot[w] + 1;
        res_q.push_back('{1'b1, 1'b1, w, last_run_seq[w], dispatch_tot[w],
                          dwq_pkg::CntW'(ring_q.size()), ring_q.size() == 0});
      end
    end else begin
      case (dwq_pkg::op_e'(op))
        dwq_pkg::OP_QUEUE: begin
          if (!pend_flag[id] && ring_q.size() < dwq_pkg::QueueDepth) begin
            pend_flag[id] = 1'b1;
            cancel_mark[id] = 1'b0;
            ring_q.push_back(id);
            acc = 1'b1;
          end
        end
        dwq_pkg::OP_CANCEL, dwq_pkg::OP_CANCEL_SYNC: begin
          acc = pend_flag[id];
          if (pend_flag[id]) begin
            // later entries move up one slot
            for (i = 0; i < ring_q.size(); i++) begin
              if (ring_q[i] == id) begin
                ring_q.delete(i);
                break;
              end
            end
            pend_flag[id] = 1'b0;
          end
          if (acc || dwq_pkg::op_e'(op) == dwq_pkg::OP_CANCEL_SYNC) cancel_mark[id] = 1'b1;
        end
        dwq_pkg::OP_FLUSH: acc = 1'b1;
        dwq_pkg::OP_CLEAR: begin
          last_run_seq[id] = '0;
          dispatch_tot[id] = '0;
          cancel_mark[id] = 1'b0;
          acc = 1'b1;
        end
        default: ;
      endcase
      res_q.push_back('{acc, 1'b0, id, last_run_seq[id], dispatch_tot[id],
                        dwq_pkg::CntW'(ring_q.size()), 1'b1});
    end
    if (typed) due_results.push_back(want);
    else foreach (res_q[k]) due_results.push_back(res_q[k]);
  endfunction

  task automatic offer_item(input logic [dwq_pkg::OpW-1:0] op,
                            input logic [dwq_pkg::IdW-1:0] id,
                            input bit typed, input dwq_result_t want);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.operation <= op;
    req_bus.work_id   <= id;
    do @(posedge clk_i); while (!req_bus.ready);
    work_queue_step(op, id, typed, want);
  endtask

  // Request side
  initial begin
    logic [dwq_pkg::OpW-1:0] op;
    logic [dwq_pkg::IdW-1:0] id;
    bit                      fill_phase;
    int                      r;
    rst_ni            = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.operation = '0;
    req_bus.work_id   = '0;
    hold_rsp          = 1'b0;
    steady            = 1'b0;
    fill_phase        = 1'b0;
    mismatches        = 0;
    run_seq           = '0;
    foreach (pend_flag[k]) begin
      pend_flag[k]    = 1'b0;
      cancel_mark[k]  = 1'b0;
      last_run_seq[k] = '0;
      dispatch_tot[k] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) offer_item(dir_rows[k].op, dir_rows[k].id, dir_rows[k].typed,
                                     dir_rows[k].want);

    for (int n = 0; n < RandItems; n++) begin
      if (n % 25 == 0) begin
        fill_phase = $urandom_range(0, 1);
        steady     = ($urandom_range(0, 2) == 0);
      end
      if (n == 10 || n == 60) hold_rsp = 1'b1;
      r = $urandom_range(0, 99);
      if (fill_phase) begin
        op = (r < 70) ? dwq_pkg::OP_QUEUE : (r < 78) ? dwq_pkg::OP_CANCEL :
             (r < 84) ? dwq_pkg::OP_CANCEL_SYNC : (r < 90) ? dwq_pkg::OP_FLUSH :
             (r < 96) ? dwq_pkg::OP_CLEAR : 3'($urandom_range(5, 7));
      end else begin
        op = (r < 40) ? dwq_pkg::OP_QUEUE : (r < 55) ? dwq_pkg::OP_CANCEL :
             (r < 65) ? dwq_pkg::OP_CANCEL_SYNC : (r < 80) ? dwq_pkg::OP_FLUSH :
             (r < 94) ? dwq_pkg::OP_CLEAR : 3'($urandom_range(5, 7));
      end
      id = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 23));
      // aim most cancels at an id that is actually in the ring
      if ((dwq_pkg::op_e'(op) == dwq_pkg::OP_CANCEL ||
           dwq_pkg::op_e'(op) == dwq_pkg::OP_CANCEL_SYNC) && ring_q.size() != 0 &&
          $urandom_range(0, 3) != 0)
        id = ring_q[$urandom_range(0, ring_q.size() - 1)];
      offer_item(op, id, 1'b0, NoWant);
    end
    req_bus.valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: random stalls, plus long hold-offs on request
  initial begin
    int on_len;
    int off_len;
    rsp_bus.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_rsp) begin
        rsp_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      on_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      rsp_bus.ready <= 1'b1;
      repeat (on_len) @(posedge clk_i);
      off_len = pick_gap();
      if (off_len > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (off_len) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    dwq_result_t seen;
    dwq_result_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      seen = '{rsp_bus.accepted, rsp_bus.dispatched, rsp_bus.dispatched_id, rsp_bus.run_stamp,
               rsp_bus.run_count, rsp_bus.pending_count, rsp_bus.last};
      if (due_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected beat: acc %0d disp %0d id %0d order %0d count %0d pend %0d last %0d",
                   seen.accepted, seen.dispatched, seen.dispatched_id, seen.run_stamp,
                   seen.run_count, seen.pending_count, seen.last);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (seen.accepted !== want.accepted || seen.dispatched !== want.dispatched ||
            seen.dispatched_id !== want.dispatched_id || seen.run_stamp !== want.run_stamp ||
            seen.run_count !== want.run_count || seen.pending_count !== want.pending_count ||
            seen.last !== want.last) begin
          if (mismatches < 10) begin
            $display("mismatch: exp acc %0d disp %0d id %0d order %0d count %0d pend %0d last %0d",
                     want.accepted, want.dispatched, want.dispatched_id, want.run_stamp,
                     want.run_count, want.pending_count, want.last);
            $display("          got acc %0d disp %0d id %0d order %0d count %0d pend %0d last %0d",
                     seen.accepted, seen.dispatched, seen.dispatched_id, seen.run_stamp,
                     seen.run_count, seen.pending_count, seen.last);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
